FILE: rtl/erfa_pkg.sv
// Shared types and constants of the erf/erfc approximation unit.
// Internal arithmetic is Q.30; this package depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
package erfa_pkg;

    localparam int IFB          = 30;
    localparam int T_W          = 31;
    localparam int DEN_W        = 33;
    localparam int SQ_W         = 36;
    localparam int ACC_W        = 34;
    localparam int E_W          = 38;
    localparam int M_W          = 36;
    localparam int R_W          = 30;
    localparam int N_W          = 6;
    localparam int SUM_W        = 32;
    localparam int Z_W          = 32;
    localparam int RES_W        = 34;
    localparam int HORNER_STEPS = 8;
    localparam int RDIV_STAGES  = 6;
    localparam int TAY_TERMS    = 14;
    localparam int TAY_STAGES   = 2 * TAY_TERMS;
    localparam int EXP_N_MAX    = 47;

    localparam logic OP_ERF  = 1'b0;
    localparam logic OP_ERFC = 1'b1;

    localparam logic [63:0] Q_SCALE = 64'd1 << IFB;
    localparam logic [63:0] DEC8    = 64'd100000000;
    localparam logic [63:0] DEC8_RND = 64'd50000000;
    localparam logic [63:0] DEC9    = 64'd1000000000;
    localparam logic [63:0] DEC9_RND = 64'd500000000;

    localparam logic signed [ACC_W-1:0] COEF [HORNER_STEPS+1] = '{
        ACC_W'((64'd100002368 * Q_SCALE + DEC8_RND) / DEC8),
        ACC_W'((64'd37409196 * Q_SCALE + DEC8_RND) / DEC8),
        ACC_W'((64'd9678418 * Q_SCALE + DEC8_RND) / DEC8),
        ACC_W'(64'd0 - (64'd18628806 * Q_SCALE + DEC8_RND) / DEC8),
        ACC_W'((64'd27886807 * Q_SCALE + DEC8_RND) / DEC8),
        ACC_W'(64'd0 - (64'd113520398 * Q_SCALE + DEC8_RND) / DEC8),
        ACC_W'((64'd148851587 * Q_SCALE + DEC8_RND) / DEC8),
        ACC_W'(64'd0 - (64'd82215223 * Q_SCALE + DEC8_RND) / DEC8),
        ACC_W'((64'd17087277 * Q_SCALE + DEC8_RND) / DEC8)
    };

    localparam logic [E_W-1:0] OFFSET_Q = E_W'((64'd126551223 * Q_SCALE + DEC8_RND) / DEC8);
    localparam logic [R_W-1:0] LN2_Q = R_W'((64'd693147181 * Q_SCALE + DEC9_RND) / DEC9);
    localparam logic signed [E_W-1:0] E_FLOOR = E_W'(64'd0 - (64'd32 << IFB));

    // Reciprocal multipliers: floor(p / k) == (p * MUL) >> SHIFT for p below 2^31.
    localparam logic [31:0] TAY_MUL [TAY_TERMS] = '{
        32'd2147483648, 32'd2147483648, 32'd2863311531, 32'd2147483648,
        32'd3435973837, 32'd2863311531, 32'd2454267027, 32'd2147483648,
        32'd3817748708, 32'd3435973837, 32'd3123612579, 32'd2863311531,
        32'd2643056798, 32'd2454267027
    };
    localparam logic [5:0] TAY_SHIFT [TAY_TERMS] = '{
        6'd31, 6'd32, 6'd33, 6'd33, 6'd34, 6'd34, 6'd34,
        6'd34, 6'd35, 6'd35, 6'd35, 6'd35, 6'd35, 6'd35
    };

    typedef struct packed {
        logic op;
        logic neg;
        logic zero;
    } flags_t;

    typedef struct packed {
        logic [M_W-1:0] rem;
        logic [N_W-1:0] quo;
        logic           pos;
        logic [R_W-1:0] rpos;
    } rdiv_t;

    typedef struct packed {
        logic [R_W-1:0]   r;
        logic [N_W-1:0]   n;
        logic [SUM_W-1:0] sum;
        logic [T_W-1:0]   term;
    } tay_t;

endpackage
`default_nettype wire

FILE: rtl/erf_erfc_approximation_unit.sv
// Top level of the erf/erfc approximation unit: input stage, |x|^2, Horner chain,
// final scaling and clamping. Depends on erfa_pkg, erfa_div and erfa_exp.
`timescale 1ns / 1ps
`default_nettype none
// The unit takes one argument beat per cycle while the output is not held and returns one
// result beat per argument, in order. The pipeline is made of the 31-stage reciprocal divider
// for t, eight Horner multiply stages and the 36-stage exponential (six range reduction
// stages, one setup stage, two multiply stages for each of 14 series terms and one rounding
// shift stage), plus five stages for input, square, exponent, product and output. When
// m_ready holds a result, the whole pipeline stalls and s_ready falls.
module erf_erfc_approximation_unit #(
    parameter int FRAC_BITS = 16,
    parameter int INT_BITS  = 4
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic                                   s_op,
    input  wire logic signed [INT_BITS+FRAC_BITS-1:0]   s_arg,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed [FRAC_BITS+2:0]                 m_value
);
    localparam int IN_W  = INT_BITS + FRAC_BITS;
    localparam int OUT_W = FRAC_BITS + 3;
    localparam int AX_W  = FRAC_BITS + 3;
    localparam int AXE_W = (IN_W > FRAC_BITS + 4) ? IN_W : FRAC_BITS + 4;
    localparam int SH    = erfa_pkg::IFB - FRAC_BITS;
    localparam int HS    = (SH > 0) ? (1 << (SH - 1)) : 0;
    localparam int SQ_LS = erfa_pkg::IFB - 2 * FRAC_BITS;
    localparam int HN    = erfa_pkg::HORNER_STEPS;
    localparam int ACW   = erfa_pkg::ACC_W;
    localparam int TW    = erfa_pkg::T_W;
    localparam int PW    = erfa_pkg::ACC_W + erfa_pkg::T_W;
    localparam int ZPW   = erfa_pkg::T_W + erfa_pkg::SUM_W;
    localparam int RSW   = erfa_pkg::RES_W;

    logic en;

    logic              s0_vld_reg;
    erfa_pkg::flags_t  s0_flags_reg;
    logic [AX_W-1:0]   s0_ax_reg;
    erfa_pkg::flags_t  s0_flags_next;
    logic [AX_W-1:0]   s0_ax_next;

    logic                         s1_vld_reg;
    erfa_pkg::flags_t             s1_flags_reg;
    logic [erfa_pkg::DEN_W-1:0]   s1_den_reg;
    logic [erfa_pkg::SQ_W-1:0]    s1_sq_reg;
    logic [erfa_pkg::DEN_W-1:0]   s1_den_next;
    logic [erfa_pkg::SQ_W-1:0]    s1_sq_next;
    logic [2*AX_W-1:0]            sq_prod;

    logic                         dv_valid;
    logic [TW-1:0]                dv_t;
    erfa_pkg::flags_t             dv_flags;
    logic [erfa_pkg::SQ_W-1:0]    dv_sq;

    logic                         hr_vld_reg   [HN];
    logic signed [ACW-1:0]        hr_acc_reg   [HN];
    logic [TW-1:0]                hr_t_reg     [HN];
    logic [erfa_pkg::SQ_W-1:0]    hr_sq_reg    [HN];
    erfa_pkg::flags_t             hr_flags_reg [HN];
    logic signed [ACW-1:0]        hr_acc_next  [HN];

    logic                            ee_vld_reg;
    logic signed [erfa_pkg::E_W-1:0] ee_e_reg;
    logic [TW-1:0]                   ee_t_reg;
    erfa_pkg::flags_t                ee_flags_reg;
    logic signed [erfa_pkg::E_W-1:0] ee_e_next;
    erfa_pkg::flags_t                ee_flags_next;

    logic                          ex_valid;
    logic [erfa_pkg::SUM_W-1:0]    ex_exp;
    erfa_pkg::flags_t              ex_flags;
    logic [TW-1:0]                 ex_t;

    logic                        z_vld_reg;
    logic [erfa_pkg::Z_W-1:0]    z_reg;
    erfa_pkg::flags_t            z_flags_reg;
    logic [erfa_pkg::Z_W-1:0]    z_next;

    logic                        m_valid_reg;
    logic signed [OUT_W-1:0]     m_value_reg;
    logic signed [OUT_W-1:0]     m_value_next;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    always_comb begin : p_input
        logic [IN_W-1:0]  ax_abs;
        logic [AXE_W-1:0] ax_ext;
        ax_abs = s_arg[IN_W-1] ? IN_W'(-s_arg) : IN_W'(s_arg);
        ax_ext = AXE_W'(ax_abs);
        s0_flags_next.op   = s_op;
        s0_flags_next.neg  = s_arg[IN_W-1];
        s0_flags_next.zero = ax_ext >= (AXE_W'(1) << (FRAC_BITS + 3));
        s0_ax_next         = ax_ext[AX_W-1:0];
    end

    assign sq_prod     = (2*AX_W)'(s0_ax_reg) * (2*AX_W)'(s0_ax_reg);
    assign s1_den_next = (erfa_pkg::DEN_W'(1) << erfa_pkg::IFB)
                       + ((erfa_pkg::DEN_W'(s0_ax_reg) << SH) >> 1);

    if (SQ_LS >= 0) begin : g_sq_left
        assign s1_sq_next = erfa_pkg::SQ_W'(sq_prod) << SQ_LS;
    end else begin : g_sq_right
        assign s1_sq_next = erfa_pkg::SQ_W'(sq_prod >> (-SQ_LS));
    end

    erfa_div #(
        .SB_W (erfa_pkg::SQ_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s1_vld_reg),
        .in_den    (s1_den_reg),
        .in_flags  (s1_flags_reg),
        .in_sb     (s1_sq_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_t),
        .out_flags (dv_flags),
        .out_sb    (dv_sq)
    );

    always_comb begin : p_horner
        logic signed [ACW-1:0] acc;
        logic [TW-1:0]         t;
        logic [ACW-1:0]        mag;
        logic [PW-1:0]         prod;
        logic signed [ACW-1:0] pm;
        for (int j = 0; j < HN; j++) begin
            acc  = (j == 0) ? erfa_pkg::COEF[HN] : hr_acc_reg[j-1];
            t    = (j == 0) ? dv_t : hr_t_reg[j-1];
            mag  = acc[ACW-1] ? ACW'(-acc) : ACW'(acc);
            prod = PW'(mag) * PW'(t);
            pm   = ACW'((prod + (PW'(1) << (erfa_pkg::IFB - 1))) >> erfa_pkg::IFB);
            hr_acc_next[j] = erfa_pkg::COEF[HN-1-j] + (acc[ACW-1] ? -pm : pm);
        end
    end

    always_comb begin : p_exponent
        logic signed [ACW-1:0] acc;
        logic [ACW-1:0]        mag;
        logic [PW-1:0]         prod;
        logic signed [ACW-1:0] pm;
        logic signed [ACW-1:0] mt;
        acc  = hr_acc_reg[HN-1];
        mag  = acc[ACW-1] ? ACW'(-acc) : ACW'(acc);
        prod = PW'(mag) * PW'(hr_t_reg[HN-1]);
        pm   = ACW'((prod + (PW'(1) << (erfa_pkg::IFB - 1))) >> erfa_pkg::IFB);
        mt   = acc[ACW-1] ? -pm : pm;
        ee_e_next = erfa_pkg::E_W'(mt) - erfa_pkg::E_W'(hr_sq_reg[HN-1])
                  - erfa_pkg::OFFSET_Q;
        ee_flags_next      = hr_flags_reg[HN-1];
        ee_flags_next.zero = hr_flags_reg[HN-1].zero || (ee_e_next < erfa_pkg::E_FLOOR);
    end

    erfa_exp #(
        .SB_W (TW)
    ) u_exp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (ee_vld_reg),
        .in_e      (ee_e_reg),
        .in_flags  (ee_flags_reg),
        .in_sb     (ee_t_reg),
        .out_valid (ex_valid),
        .out_exp   (ex_exp),
        .out_flags (ex_flags),
        .out_sb    (ex_t)
    );

    always_comb begin : p_product
        logic [ZPW-1:0] zp;
        zp     = ZPW'(ex_t) * ZPW'(ex_exp);
        z_next = ex_flags.zero ? '0 :
                 erfa_pkg::Z_W'((zp + (ZPW'(1) << (erfa_pkg::IFB - 1))) >> erfa_pkg::IFB);
    end

    always_comb begin : p_result
        logic signed [RSW-1:0] one;
        logic signed [RSW-1:0] zs;
        logic signed [RSW-1:0] res;
        logic signed [RSW-1:0] q;
        logic signed [RSW-1:0] lo;
        logic signed [RSW-1:0] hi;
        one = RSW'(1) << erfa_pkg::IFB;
        zs  = RSW'(z_reg);
        lo  = -(RSW'(1) << FRAC_BITS);
        hi  = RSW'(2) << FRAC_BITS;
        case (z_flags_reg.op)
            erfa_pkg::OP_ERF: begin
                res = z_flags_reg.neg ? zs - one : one - zs;
            end
            erfa_pkg::OP_ERFC: begin
                res = z_flags_reg.neg ? (one <<< 1) - zs : zs;
            end
            default: begin
                res = zs;
            end
        endcase
        q = (res + RSW'(HS)) >>> SH;
        if (q < lo) begin
            q = lo;
        end else if (q > hi) begin
            q = hi;
        end
        m_value_next = OUT_W'(q);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_vld_reg  <= 1'b0;
            s1_vld_reg  <= 1'b0;
            ee_vld_reg  <= 1'b0;
            z_vld_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int j = 0; j < HN; j++) begin
                hr_vld_reg[j] <= 1'b0;
            end
        end else if (en) begin
            s0_vld_reg <= s_valid;
            s1_vld_reg <= s0_vld_reg;
            for (int j = 0; j < HN; j++) begin
                hr_vld_reg[j] <= (j == 0) ? dv_valid : hr_vld_reg[j-1];
            end
            ee_vld_reg  <= hr_vld_reg[HN-1];
            z_vld_reg   <= ex_valid;
            m_valid_reg <= z_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_flags_reg <= s0_flags_next;
            s0_ax_reg    <= s0_ax_next;
            s1_flags_reg <= s0_flags_reg;
            s1_den_reg   <= s1_den_next;
            s1_sq_reg    <= s1_sq_next;
            for (int j = 0; j < HN; j++) begin
                hr_acc_reg[j]   <= hr_acc_next[j];
                hr_t_reg[j]     <= (j == 0) ? dv_t : hr_t_reg[j-1];
                hr_sq_reg[j]    <= (j == 0) ? dv_sq : hr_sq_reg[j-1];
                hr_flags_reg[j] <= (j == 0) ? dv_flags : hr_flags_reg[j-1];
            end
            ee_e_reg     <= ee_e_next;
            ee_t_reg     <= hr_t_reg[HN-1];
            ee_flags_reg <= ee_flags_next;
            z_reg        <= z_next;
            z_flags_reg  <= ex_flags;
            m_value_reg  <= m_value_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;

    a_value_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_value >= -(OUT_W'(1) << FRAC_BITS))
                 && (m_value <= (OUT_W'(2) << FRAC_BITS)))
        else $error("result outside the clamp range");

    a_reset_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_valid)
        else $error("result beat right after reset");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while the output is empty");

    a_big_arg: assert property (@(posedge aclk) disable iff (!aresetn)
        ex_valid && ex_flags.zero && en |=> z_vld_reg && z_reg == '0)
        else $error("flushed beat gave a nonzero product");

endmodule
`default_nettype wire

FILE: rtl/erfa_div.sv
// Pipelined restoring divider forming t = floor(2^60 / den), one quotient bit per stage.
// Depends on erfa_pkg; flags and a data sideband travel alongside each beat.
`timescale 1ns / 1ps
`default_nettype none
module erfa_div #(
    parameter int SB_W = 1
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [erfa_pkg::DEN_W-1:0]    in_den,
    input  wire erfa_pkg::flags_t              in_flags,
    input  wire logic [SB_W-1:0]               in_sb,
    output logic                               out_valid,
    output logic [erfa_pkg::T_W-1:0]           out_quo,
    output erfa_pkg::flags_t                   out_flags,
    output logic [SB_W-1:0]                    out_sb
);
    localparam int QW = erfa_pkg::T_W;
    localparam int DW = erfa_pkg::DEN_W;
    localparam int RW = DW + 1;

    logic              vld_reg   [QW];
    logic [RW-1:0]     rem_reg   [QW];
    logic [QW-1:0]     quo_reg   [QW];
    logic [DW-1:0]     den_reg   [QW];
    erfa_pkg::flags_t  flags_reg [QW];
    logic [SB_W-1:0]   sb_reg    [QW];

    logic              vld_next   [QW];
    logic [RW-1:0]     rem_next   [QW];
    logic [QW-1:0]     quo_next   [QW];
    logic [DW-1:0]     den_next   [QW];
    erfa_pkg::flags_t  flags_next [QW];
    logic [SB_W-1:0]   sb_next    [QW];

    always_comb begin : p_next
        logic [RW-1:0] rem_cur;
        logic [QW-1:0] quo_cur;
        logic [DW-1:0] den_cur;
        logic [RW-1:0] rem_sub;
        logic          ge;
        for (int i = 0; i < QW; i++) begin
            if (i == 0) begin
                rem_cur       = RW'(1) << erfa_pkg::IFB;
                quo_cur       = '0;
                den_cur       = in_den;
                vld_next[i]   = in_valid;
                flags_next[i] = in_flags;
                sb_next[i]    = in_sb;
            end else begin
                rem_cur       = rem_reg[i-1];
                quo_cur       = quo_reg[i-1];
                den_cur       = den_reg[i-1];
                vld_next[i]   = vld_reg[i-1];
                flags_next[i] = flags_reg[i-1];
                sb_next[i]    = sb_reg[i-1];
            end
            ge          = rem_cur >= RW'(den_cur);
            rem_sub     = ge ? rem_cur - RW'(den_cur) : rem_cur;
            rem_next[i] = rem_sub << 1;
            quo_next[i] = quo_cur | (QW'(ge) << (QW - 1 - i));
            den_next[i] = den_cur;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < QW; i++) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= vld_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < QW; i++) begin
                rem_reg[i]   <= rem_next[i];
                quo_reg[i]   <= quo_next[i];
                den_reg[i]   <= den_next[i];
                flags_reg[i] <= flags_next[i];
                sb_reg[i]    <= sb_next[i];
            end
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign out_quo   = quo_reg[QW-1];
    assign out_flags = flags_reg[QW-1];
    assign out_sb    = sb_reg[QW-1];

    a_quo_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (out_quo <= (QW'(1) << erfa_pkg::IFB)) && (out_quo != '0))
        else $error("reciprocal t out of range");

endmodule
`default_nettype wire

FILE: rtl/erfa_exp.sv
// Pipelined exp(e) for e <= ln2: range reduction by ln2, a 14-term series, and
// a rounding right shift. Depends on erfa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module erfa_exp #(
    parameter int SB_W = 1
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                en,
    input  wire logic                                in_valid,
    input  wire logic signed [erfa_pkg::E_W-1:0]     in_e,
    input  wire erfa_pkg::flags_t                    in_flags,
    input  wire logic [SB_W-1:0]                     in_sb,
    output logic                                     out_valid,
    output logic [erfa_pkg::SUM_W-1:0]               out_exp,
    output erfa_pkg::flags_t                         out_flags,
    output logic [SB_W-1:0]                          out_sb
);
    localparam int RD = erfa_pkg::RDIV_STAGES;
    localparam int TS = erfa_pkg::TAY_STAGES;
    localparam int MW = erfa_pkg::M_W;
    localparam int RW = erfa_pkg::R_W;
    localparam int TW = erfa_pkg::T_W;
    localparam int SW = erfa_pkg::SUM_W;
    localparam int NW = erfa_pkg::N_W;

    logic              rd_vld_reg   [RD];
    erfa_pkg::rdiv_t   rd_reg       [RD];
    erfa_pkg::flags_t  rd_flags_reg [RD];
    logic [SB_W-1:0]   rd_sb_reg    [RD];
    erfa_pkg::rdiv_t   rd_next      [RD];

    logic              nr_vld_reg;
    erfa_pkg::tay_t    nr_reg;
    erfa_pkg::flags_t  nr_flags_reg;
    logic [SB_W-1:0]   nr_sb_reg;
    erfa_pkg::tay_t    nr_next;

    logic              tay_vld_reg   [TS];
    erfa_pkg::tay_t    tay_reg       [TS];
    erfa_pkg::flags_t  tay_flags_reg [TS];
    logic [SB_W-1:0]   tay_sb_reg    [TS];
    erfa_pkg::tay_t    tay_next      [TS];

    logic              out_vld_reg;
    logic [SW-1:0]     exp_reg;
    erfa_pkg::flags_t  out_flags_reg;
    logic [SB_W-1:0]   out_sb_reg;
    logic [SW-1:0]     exp_next;

    always_comb begin : p_rdiv
        erfa_pkg::rdiv_t cur;
        logic [MW-1:0]   dv;
        logic            ge;
        for (int i = 0; i < RD; i++) begin
            if (i == 0) begin
                cur.rem  = MW'(erfa_pkg::E_W'(0) - in_e);
                cur.quo  = '0;
                cur.pos  = !in_e[erfa_pkg::E_W-1];
                cur.rpos = (in_e < erfa_pkg::E_W'(erfa_pkg::LN2_Q)) ?
                           in_e[RW-1:0] : erfa_pkg::LN2_Q - RW'(1);
            end else begin
                cur = rd_reg[i-1];
            end
            dv         = MW'(erfa_pkg::LN2_Q) << (RD - 1 - i);
            ge         = cur.rem >= dv;
            rd_next[i] = cur;
            if (ge) begin
                rd_next[i].rem = cur.rem - dv;
            end
            rd_next[i].quo = cur.quo | (NW'(ge) << (RD - 1 - i));
        end
    end

    always_comb begin : p_reduce
        erfa_pkg::rdiv_t last;
        logic            rz;
        last         = rd_reg[RD-1];
        rz           = last.rem == '0;
        nr_next.sum  = SW'(1) << erfa_pkg::IFB;
        nr_next.term = TW'(1) << erfa_pkg::IFB;
        if (last.pos) begin
            nr_next.n = '0;
            nr_next.r = last.rpos;
        end else begin
            nr_next.n = last.quo + NW'(!rz);
            nr_next.r = rz ? '0 : erfa_pkg::LN2_Q - RW'(last.rem);
        end
    end

    always_comb begin : p_series
        erfa_pkg::tay_t    src;
        logic [TW+RW-1:0]  pa;
        logic [TW+32-1:0]  pb;
        logic [TW-1:0]     q;
        for (int j = 0; j < TS; j++) begin
            src         = (j == 0) ? nr_reg : tay_reg[j-1];
            tay_next[j] = src;
            if ((j & 1) == 0) begin
                pa               = (TW+RW)'(src.term) * (TW+RW)'(src.r);
                tay_next[j].term = TW'(pa >> erfa_pkg::IFB);
            end else begin
                pb               = (TW+32)'(src.term) * (TW+32)'(erfa_pkg::TAY_MUL[j>>1]);
                q                = TW'(pb >> erfa_pkg::TAY_SHIFT[j>>1]);
                tay_next[j].term = q;
                tay_next[j].sum  = src.sum + SW'(q);
            end
        end
    end

    always_comb begin : p_scale
        erfa_pkg::tay_t last;
        logic [47:0]    sh;
        last = tay_reg[TS-1];
        sh   = (48'(last.sum) + ((48'd1 << last.n) >> 1)) >> last.n;
        exp_next = tay_flags_reg[TS-1].zero ? '0 : SW'(sh);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < RD; i++) begin
                rd_vld_reg[i] <= 1'b0;
            end
            for (int j = 0; j < TS; j++) begin
                tay_vld_reg[j] <= 1'b0;
            end
            nr_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            for (int i = 0; i < RD; i++) begin
                rd_vld_reg[i] <= (i == 0) ? in_valid : rd_vld_reg[i-1];
            end
            nr_vld_reg <= rd_vld_reg[RD-1];
            for (int j = 0; j < TS; j++) begin
                tay_vld_reg[j] <= (j == 0) ? nr_vld_reg : tay_vld_reg[j-1];
            end
            out_vld_reg <= tay_vld_reg[TS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < RD; i++) begin
                rd_reg[i]       <= rd_next[i];
                rd_flags_reg[i] <= (i == 0) ? in_flags : rd_flags_reg[i-1];
                rd_sb_reg[i]    <= (i == 0) ? in_sb : rd_sb_reg[i-1];
            end
            nr_reg       <= nr_next;
            nr_flags_reg <= rd_flags_reg[RD-1];
            nr_sb_reg    <= rd_sb_reg[RD-1];
            for (int j = 0; j < TS; j++) begin
                tay_reg[j]       <= tay_next[j];
                tay_flags_reg[j] <= (j == 0) ? nr_flags_reg : tay_flags_reg[j-1];
                tay_sb_reg[j]    <= (j == 0) ? nr_sb_reg : tay_sb_reg[j-1];
            end
            exp_reg       <= exp_next;
            out_flags_reg <= tay_flags_reg[TS-1];
            out_sb_reg    <= tay_sb_reg[TS-1];
        end
    end

    assign out_valid = out_vld_reg;
    assign out_exp   = exp_reg;
    assign out_flags = out_flags_reg;
    assign out_sb    = out_sb_reg;

    a_zero_exp: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && out_flags.zero |-> out_exp == '0)
        else $error("flushed beat gave a nonzero exponential");

    a_exp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> out_exp <= (SW'(1) << (erfa_pkg::IFB + 1)))
        else $error("exponential exceeds two");

    a_shift_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        nr_vld_reg && !nr_flags_reg.zero |-> nr_reg.n <= NW'(erfa_pkg::EXP_N_MAX))
        else $error("range reduction count too large");

endmodule
`default_nettype wire
